// ----- hdl/pstg_pkg.sv -----
// types and constants shared by the pulse/saw tone generator
// no dependencies

package pstg_pkg;

    localparam int unsigned ADDR_W = 16;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned CFG_W  = 16;

    localparam logic [3:0] REGION_PULSE_A = 4'h9;
    localparam logic [3:0] REGION_PULSE_B = 4'hA;
    localparam logic [3:0] REGION_SAW     = 4'hB;

    localparam logic [1:0] REG_CTRL      = 2'd0;
    localparam logic [1:0] REG_PERIOD_LO = 2'd1;
    localparam logic [1:0] REG_PERIOD_HI = 2'd2;

    localparam logic CFG_LINE0_MASK = 1'b0;
    localparam logic CFG_LINE1_MASK = 1'b1;

    localparam logic [CFG_W-1:0] LINE0_MASK_RESET = 16'h0001;
    localparam logic [CFG_W-1:0] LINE1_MASK_RESET = 16'h0002;

    localparam logic [3:0] SAW_WRAP_PHASE = 4'd14;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [3:0] pulse_a_level;
        logic [3:0] pulse_b_level;
        logic [7:0] saw_level;
    } t_out_item;

    typedef struct packed {
        logic              wr;
        logic              tick;
        logic [1:0]        idx;
        logic [DATA_W-1:0] data;
    } t_chan_ctl;

endpackage

// ----- hdl/pulse_saw_tone_generator_unit.sv -----
// top level of the pulse/saw tone generator: input register, address decode, result register
// depends on pstg_pkg, pstg_pulse, pstg_saw

// Takes one transaction per clock cycle while input ready is high (a bus write or an audio
// tick) and returns one transaction with the three voice levels after it. The item is
// captured in an input register, every voice updates its state from it, and the levels
// land in a result register. The result register decouples the two sides, so a new
// item is taken while a result waits; input ready drops only while both registers are full
// and the output is stalled. The address masks are written through the config port.

module pulse_saw_tone_generator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [pstg_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pstg_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pstg_pkg::t_out_item         o_out_item
);

    logic [pstg_pkg::CFG_W-1:0] r_line0_mask;
    logic [pstg_pkg::CFG_W-1:0] r_line1_mask;

    logic               r_in_valid;
    pstg_pkg::t_in_item r_in_item;
    logic                r_out_valid;
    pstg_pkg::t_out_item r_out_item;

    logic                advance;
    logic [1:0]          idx;
    logic [3:0]          region;
    logic                is_write;
    pstg_pkg::t_chan_ctl ctl_a;
    pstg_pkg::t_chan_ctl ctl_b;
    pstg_pkg::t_chan_ctl ctl_saw;
    pstg_pkg::t_out_item n_out_item;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line0_mask <= pstg_pkg::LINE0_MASK_RESET;
            r_line1_mask <= pstg_pkg::LINE1_MASK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pstg_pkg::CFG_LINE0_MASK: r_line0_mask <= i_cfg_data;
                pstg_pkg::CFG_LINE1_MASK: r_line1_mask <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign idx      = {|(r_in_item.bus_address & r_line1_mask),
                       |(r_in_item.bus_address & r_line0_mask)};
    assign region   = r_in_item.bus_address[15:12];
    assign is_write = advance && !r_in_item.command;

    always_comb begin
        ctl_a.wr     = is_write && (region == pstg_pkg::REGION_PULSE_A);
        ctl_a.tick   = advance && r_in_item.command;
        ctl_a.idx    = idx;
        ctl_a.data   = r_in_item.write_data;
        ctl_b        = ctl_a;
        ctl_b.wr     = is_write && (region == pstg_pkg::REGION_PULSE_B);
        ctl_saw      = ctl_a;
        ctl_saw.wr   = is_write && (region == pstg_pkg::REGION_SAW);
    end

    pstg_pulse u_pulse_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl_a),
        .o_level_next (n_out_item.pulse_a_level)
    );

    pstg_pulse u_pulse_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl_b),
        .o_level_next (n_out_item.pulse_b_level)
    );

    pstg_saw u_saw (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl_saw),
        .o_level_next (n_out_item.saw_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- hdl/pstg_pulse.sv -----
// one pulse voice: register file, countdown timer, 16-step duty sequencer
// depends on pstg_pkg

module pstg_pulse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pstg_pkg::t_chan_ctl i_ctl,
    output logic [3:0]        o_level_next
);

    logic [3:0]  r_volume,    n_volume;
    logic [2:0]  r_duty,      n_duty;
    logic        r_constant,  n_constant;
    logic [11:0] r_period,    n_period;
    logic        r_on,        n_on;
    logic [12:0] r_countdown, n_countdown;
    logic [3:0]  r_phase,     n_phase;
    logic [3:0]  r_out,       n_out;

    logic [12:0] cd_dec;
    logic [3:0]  phase_inc;

    assign cd_dec    = r_countdown - 13'd1;
    assign phase_inc = r_phase + 4'd1;

    always_comb begin
        n_volume    = r_volume;
        n_duty      = r_duty;
        n_constant  = r_constant;
        n_period    = r_period;
        n_on        = r_on;
        n_countdown = r_countdown;
        n_phase     = r_phase;
        n_out       = r_out;
        if (i_ctl.wr) begin
            unique case (i_ctl.idx)
                pstg_pkg::REG_CTRL: begin
                    n_volume   = i_ctl.data[3:0];
                    n_duty     = i_ctl.data[6:4];
                    n_constant = i_ctl.data[7];
                end
                pstg_pkg::REG_PERIOD_LO: begin
                    n_period[7:0] = i_ctl.data;
                end
                pstg_pkg::REG_PERIOD_HI: begin
                    n_period[11:8] = i_ctl.data[3:0];
                    n_on           = i_ctl.data[7];
                end
                default: begin
                end
            endcase
        end else if (i_ctl.tick) begin
            n_countdown = cd_dec;
            if (cd_dec == '0) begin
                n_phase     = phase_inc;
                n_countdown = {1'b0, r_period} + 13'd1;
                if (r_on) begin
                    if (r_constant || (phase_inc <= {1'b0, r_duty})) begin
                        n_out = r_volume;
                    end else begin
                        n_out = '0;
                    end
                end
            end
            if (!r_on) begin
                n_out = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume    <= '0;
            r_duty      <= 3'd1;
            r_constant  <= 1'b0;
            r_period    <= '0;
            r_on        <= 1'b0;
            r_countdown <= 13'd1;
            r_phase     <= '0;
            r_out       <= '0;
        end else begin
            r_volume    <= n_volume;
            r_duty      <= n_duty;
            r_constant  <= n_constant;
            r_period    <= n_period;
            r_on        <= n_on;
            r_countdown <= n_countdown;
            r_phase     <= n_phase;
            r_out       <= n_out;
        end
    end

    assign o_level_next = n_out;

endmodule

// ----- hdl/pstg_saw.sv -----
// sawtooth voice: register file, countdown timer, accumulating 14-step ramp
// depends on pstg_pkg

module pstg_saw (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pstg_pkg::t_chan_ctl i_ctl,
    output logic [7:0]        o_level_next
);

    logic [5:0]  r_rate,      n_rate;
    logic [11:0] r_period,    n_period;
    logic        r_on,        n_on;
    logic [12:0] r_countdown, n_countdown;
    logic [3:0]  r_phase,     n_phase;
    logic [7:0]  r_sum,       n_sum;
    logic [7:0]  r_out,       n_out;

    logic [12:0] cd_dec;
    logic [3:0]  phase_inc;
    logic [7:0]  sum_step;

    assign cd_dec    = r_countdown - 13'd1;
    assign phase_inc = r_phase + 4'd1;
    // accumulate only on even nonzero steps
    assign sum_step  = ((r_phase != '0) && !r_phase[0]) ? (r_sum + {2'b00, r_rate}) : r_sum;

    always_comb begin
        n_rate      = r_rate;
        n_period    = r_period;
        n_on        = r_on;
        n_countdown = r_countdown;
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_out       = r_out;
        if (i_ctl.wr) begin
            unique case (i_ctl.idx)
                pstg_pkg::REG_CTRL: begin
                    n_rate = i_ctl.data[5:0];
                end
                pstg_pkg::REG_PERIOD_LO: begin
                    n_period[7:0] = i_ctl.data;
                end
                pstg_pkg::REG_PERIOD_HI: begin
                    n_period[11:8] = i_ctl.data[3:0];
                    n_on           = i_ctl.data[7];
                end
                default: begin
                end
            endcase
        end else if (i_ctl.tick) begin
            n_countdown = cd_dec;
            if (cd_dec == '0) begin
                n_countdown = {1'b0, r_period} + 13'd1;
                if (phase_inc == pstg_pkg::SAW_WRAP_PHASE) begin
                    n_phase = '0;
                    n_sum   = '0;
                end else begin
                    n_phase = phase_inc;
                    n_sum   = sum_step;
                end
                if (r_on) begin
                    n_out = n_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= '0;
            r_period    <= '0;
            r_on        <= 1'b0;
            r_countdown <= 13'd1;
            r_phase     <= '0;
            r_sum       <= '0;
            r_out       <= '0;
        end else begin
            r_rate      <= n_rate;
            r_period    <= n_period;
            r_on        <= n_on;
            r_countdown <= n_countdown;
            r_phase     <= n_phase;
            r_sum       <= n_sum;
            r_out       <= n_out;
        end
    end

    assign o_level_next = n_out;

endmodule

// ----- hdl/pstg_checker.sv -----
// port-level checks for the pulse/saw tone generator, bound to the top level
// depends on pstg_pkg and pulse_saw_tone_generator_unit

module pstg_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input pstg_pkg::t_out_item o_out_item
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input backpressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output stall");

    // an accepted transaction with empty output shows up after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> ##1 o_out_valid)
        else $error("result missing after accepted transaction");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind pulse_saw_tone_generator_unit pstg_checker u_pstg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
